// ===== sv/afv_pkg.sv =====
// Shared types, constants and helper functions of the authenticated frame verifier.
`default_nettype none
package afv_pkg;

    localparam int KEY_BYTES = 16;
    localparam int ARGS_MAX  = 32;

    localparam int POS_W = 9;
    localparam int KW    = $clog2(KEY_BYTES) + 1;
    localparam int AW    = (ARGS_MAX > 1) ? $clog2(ARGS_MAX) : 1;
    localparam int CW    = $clog2(ARGS_MAX + 1);

    localparam logic [POS_W-1:0] POS_SAT        = {POS_W{1'b1}};
    localparam logic [POS_W-1:0] FRAME_OVERHEAD = POS_W'(15);
    localparam logic [15:0]      CRC_INIT       = 16'hFFFF;
    localparam logic [15:0]      CRC_POLY       = 16'h1021;
    localparam logic [31:0]      HASH_BASIS     = 32'h811C9DC5;
    localparam logic [31:0]      HASH_MUL1      = 32'h01000193;
    localparam logic [31:0]      HASH_MUL2      = 32'h2545F491;

    localparam logic [2:0] REG_MAGIC   = 3'd0;
    localparam logic [2:0] REG_VERSION = 3'd1;
    localparam logic [2:0] REG_KEY_LO  = 3'd2;
    localparam logic [2:0] REG_KEY_HI  = 3'd3;
    localparam logic [2:0] REG_REPLAY  = 3'd4;

    localparam logic [2:0] STS_OK     = 3'd0;
    localparam logic [2:0] STS_LENGTH = 3'd1;
    localparam logic [2:0] STS_HEADER = 3'd2;
    localparam logic [2:0] STS_ARGS   = 3'd3;
    localparam logic [2:0] STS_CRC    = 3'd4;
    localparam logic [2:0] STS_MAC    = 3'd5;
    localparam logic [2:0] STS_REPLAY = 3'd6;

    typedef struct packed {
        logic [7:0]   magic;
        logic [7:0]   version;
        logic [127:0] key;
        logic         replay;
    } t_cfg;

    typedef struct packed {
        logic [7:0]       b;
        logic [POS_W-1:0] pos;
        logic             fin;
    } t_qent;

    typedef enum logic [3:0] {
        ST_IDLE, ST_BYTE, ST_KEY, ST_MUL1, ST_MUL2,
        ST_CHECK, ST_STATUS, ST_ARGRD, ST_ARGOUT
    } t_state;

    typedef enum logic [1:0] {
        PH_BYTE, PH_PRE, PH_POST
    } t_phase;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [7:0] key_byte(input logic [127:0] key, input logic [3:0] idx);
        return key[{idx, 3'b000} +: 8];
    endfunction

endpackage
`default_nettype wire

// ===== sv/auth_frame_verifier_core.sv =====
// Top level of the authenticated frame verifier: configuration registers, front and back end.
`default_nettype none
// Frame bytes enter one transaction at a time, from the length byte onwards,
// with i_frame_end set on the final byte. A two-entry queue separates the
// byte intake from the checking engine, so bytes keep being taken while the
// engine works or while a result waits at the output, until the queue holds
// two entries. The engine takes one byte at a time from the queue, in the idle
// state, and then updates the CRC and the header fields in the byte state. A
// byte that goes through the keyed hash then passes a round of two
// multiplications in two registered stages. The key is mixed in sixteen hash
// rounds before the first byte of a frame and after its final byte, ahead of
// the check and status states that give the verdict. Each argument byte
// result after the status result is read from the registered argument store
// before it is loaded. Configuration writes are always taken and must only be
// issued while the block is idle.
module auth_frame_verifier_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_frame_end,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_kind,
    output logic [2:0]       o_status,
    output logic [31:0]      o_msg_counter,
    output logic [7:0]       o_command,
    output logic [5:0]       o_arg_count,
    output logic [7:0]       o_arg_byte,
    output logic [4:0]       o_arg_index,
    output logic             o_run_end
);

    afv_pkg::t_cfg  r_cfg;
    afv_pkg::t_qent w_q_data;
    logic           w_q_valid, w_q_pop;

    assign o_cfg_ready = 1'b1;

    // The register file; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{magic: 8'h00, version: 8'h00, key: '0, replay: 1'b1};
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                afv_pkg::REG_MAGIC:   r_cfg.magic       <= i_cfg_data[7:0];
                afv_pkg::REG_VERSION: r_cfg.version     <= i_cfg_data[7:0];
                afv_pkg::REG_KEY_LO:  r_cfg.key[63:0]   <= i_cfg_data;
                afv_pkg::REG_KEY_HI:  r_cfg.key[127:64] <= i_cfg_data;
                afv_pkg::REG_REPLAY:  r_cfg.replay      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    afv_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_rx_byte   (i_rx_byte),
        .i_frame_end (i_frame_end),
        .o_q_valid   (w_q_valid),
        .o_q_data    (w_q_data),
        .i_q_pop     (w_q_pop)
    );

    afv_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_valid     (w_q_valid),
        .i_q_data      (w_q_data),
        .o_q_pop       (w_q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_kind        (o_kind),
        .o_status      (o_status),
        .o_msg_counter (o_msg_counter),
        .o_command     (o_command),
        .o_arg_count   (o_arg_count),
        .o_arg_byte    (o_arg_byte),
        .o_arg_index   (o_arg_index),
        .o_run_end     (o_run_end)
    );

endmodule
`default_nettype wire

// ===== sv/afv_front.sv =====
// Front end: accepts frame bytes, tags each with its position and queues it.
`default_nettype none
module afv_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire logic [7:0]    i_rx_byte,
    input  wire logic          i_frame_end,
    output logic               o_q_valid,
    output afv_pkg::t_qent     o_q_data,
    input  wire logic          i_q_pop
);

    afv_pkg::t_qent              r_q [2];
    logic                        r_wp, r_rp;
    logic [1:0]                  r_cnt;
    logic [afv_pkg::POS_W-1:0]   r_pos;
    logic                        w_push;

    assign o_in_stall = (r_cnt == 2'd2);
    assign w_push     = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_data   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= '{b: i_rx_byte, pos: r_pos, fin: i_frame_end};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
            r_pos <= '0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
                if (i_frame_end) begin
                    r_pos <= '0;
                end else if (r_pos != afv_pkg::POS_SAT) begin
                    r_pos <= r_pos + 1'b1;
                end
            end
            if (i_q_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_q_pop};
        end
    end

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_pos_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push && i_frame_end |=> r_pos == '0) else $error("position not restarted");
`endif

endmodule
`default_nettype wire

// ===== sv/afv_back.sv =====
// Back end: runs the CRC, the keyed hash and the frame checks, and emits the results.
`default_nettype none
module afv_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire afv_pkg::t_cfg        i_cfg,
    input  wire logic                 i_q_valid,
    input  wire afv_pkg::t_qent       i_q_data,
    output logic                      o_q_pop,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic                      o_kind,
    output logic [2:0]                o_status,
    output logic [31:0]               o_msg_counter,
    output logic [7:0]                o_command,
    output logic [5:0]                o_arg_count,
    output logic [7:0]                o_arg_byte,
    output logic [4:0]                o_arg_index,
    output logic                      o_run_end
);

    localparam int PW = afv_pkg::POS_W;

    afv_pkg::t_state r_state, n_state;
    afv_pkg::t_phase r_phase;

    logic [7:0]    r_b;
    logic [PW-1:0] r_pos;
    logic          r_fin;
    logic [31:0]   r_h, r_m1, r_ctr, r_mac, r_newest;
    logic [7:0]    r_hin, r_len, r_cmd, r_argc;
    logic [15:0]   r_crc, r_rcrc;
    logic [2:0]    r_eerr, r_st;
    logic [afv_pkg::KW-1:0] r_k;
    logic [afv_pkg::CW-1:0] r_ai;
    logic [7:0]    r_rdata;
    logic [7:0]    r_mem [afv_pkg::ARGS_MAX];

    logic          r_ovalid, r_okind, r_oend;
    logic [2:0]    r_ostatus;
    logic [31:0]   r_octr;
    logic [7:0]    r_ocmd, r_obyte;
    logic [5:0]    r_ocnt;
    logic [4:0]    r_oidx;

    logic [PW-1:0] w_rel, w_n;
    logic          w_in_args, w_do_crc, w_need_hash, w_key_done, w_arg_last;
    logic [7:0]    w_hin;
    logic [2:0]    w_st;
    logic          w_out_free, w_load_status, w_load_arg;
    logic [9:0]    w_rel_x, w_argc_x;

    // Byte classification by position within the frame.
    always_comb begin
        w_rel       = r_pos - PW'(9);
        w_rel_x     = {1'b0, w_rel};
        w_argc_x    = {2'b00, r_argc};
        w_in_args   = (r_pos >= PW'(9)) && (w_rel_x < w_argc_x);
        w_do_crc    = (r_pos < PW'(9)) || ({1'b0, r_pos} < 10'd13 + w_argc_x);
        w_need_hash = (r_pos >= PW'(2) && r_pos <= PW'(8)) || w_in_args;
        w_hin       = (r_pos == PW'(2)) ? i_cfg.version : r_b;
        w_key_done  = (r_k == afv_pkg::KW'(afv_pkg::KEY_BYTES));
        w_arg_last  = ((8'(r_ai) + 8'd1) == r_argc);
        w_n         = (r_pos == afv_pkg::POS_SAT) ? r_pos : r_pos + 1'b1;
    end

    // Final verdict, first failing check wins.
    always_comb begin
        if (w_n < afv_pkg::FRAME_OVERHEAD || ({1'b0, r_len} + PW'(1)) != w_n) begin
            w_st = afv_pkg::STS_LENGTH;
        end else if (r_eerr != afv_pkg::STS_OK) begin
            w_st = r_eerr;
        end else if (w_n != afv_pkg::FRAME_OVERHEAD + {1'b0, r_argc}) begin
            w_st = afv_pkg::STS_LENGTH;
        end else if (r_crc != r_rcrc) begin
            w_st = afv_pkg::STS_CRC;
        end else if (r_h != r_mac) begin
            w_st = afv_pkg::STS_MAC;
        end else if (i_cfg.replay && r_ctr <= r_newest) begin
            w_st = afv_pkg::STS_REPLAY;
        end else begin
            w_st = afv_pkg::STS_OK;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            afv_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    n_state = (i_q_data.pos == '0) ? afv_pkg::ST_KEY : afv_pkg::ST_BYTE;
                end
            end
            afv_pkg::ST_BYTE: begin
                if (w_need_hash) n_state = afv_pkg::ST_MUL1;
                else n_state = r_fin ? afv_pkg::ST_KEY : afv_pkg::ST_IDLE;
            end
            afv_pkg::ST_KEY:  n_state = afv_pkg::ST_MUL1;
            afv_pkg::ST_MUL1: n_state = afv_pkg::ST_MUL2;
            afv_pkg::ST_MUL2: begin
                case (r_phase)
                    afv_pkg::PH_BYTE: n_state = r_fin ? afv_pkg::ST_KEY : afv_pkg::ST_IDLE;
                    afv_pkg::PH_PRE:  n_state = w_key_done ? afv_pkg::ST_BYTE : afv_pkg::ST_KEY;
                    default:          n_state = w_key_done ? afv_pkg::ST_CHECK : afv_pkg::ST_KEY;
                endcase
            end
            afv_pkg::ST_CHECK: n_state = afv_pkg::ST_STATUS;
            afv_pkg::ST_STATUS: begin
                if (w_out_free) begin
                    n_state = (r_st != afv_pkg::STS_OK || r_argc == 8'd0)
                            ? afv_pkg::ST_IDLE : afv_pkg::ST_ARGRD;
                end
            end
            afv_pkg::ST_ARGRD: n_state = afv_pkg::ST_ARGOUT;
            afv_pkg::ST_ARGOUT: begin
                if (w_out_free) begin
                    n_state = w_arg_last ? afv_pkg::ST_IDLE : afv_pkg::ST_ARGRD;
                end
            end
            default: n_state = afv_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        w_out_free    = !r_ovalid || !i_out_stall;
        o_q_pop       = (r_state == afv_pkg::ST_IDLE) && i_q_valid;
        w_load_status = (r_state == afv_pkg::ST_STATUS) && w_out_free;
        w_load_arg    = (r_state == afv_pkg::ST_ARGOUT) && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= afv_pkg::ST_IDLE;
            r_phase  <= afv_pkg::PH_BYTE;
            r_newest <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                afv_pkg::ST_IDLE: begin
                    if (o_q_pop && i_q_data.pos == '0) r_phase <= afv_pkg::PH_PRE;
                end
                afv_pkg::ST_BYTE: begin
                    if (w_need_hash) r_phase <= afv_pkg::PH_BYTE;
                    else if (r_fin) r_phase <= afv_pkg::PH_POST;
                end
                afv_pkg::ST_MUL2: begin
                    if (r_phase == afv_pkg::PH_BYTE && r_fin) r_phase <= afv_pkg::PH_POST;
                end
                afv_pkg::ST_STATUS: begin
                    if (w_load_status && r_st == afv_pkg::STS_OK && i_cfg.replay) begin
                        r_newest <= r_ctr;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            afv_pkg::ST_IDLE: begin
                if (o_q_pop) begin
                    r_b   <= i_q_data.b;
                    r_pos <= i_q_data.pos;
                    r_fin <= i_q_data.fin;
                    if (i_q_data.pos == '0) begin
                        r_h    <= afv_pkg::HASH_BASIS;
                        r_crc  <= afv_pkg::CRC_INIT;
                        r_len  <= '0;
                        r_ctr  <= '0;
                        r_cmd  <= '0;
                        r_argc <= '0;
                        r_mac  <= '0;
                        r_rcrc <= '0;
                        r_eerr <= afv_pkg::STS_OK;
                        r_k    <= '0;
                    end
                end
            end
            afv_pkg::ST_KEY: begin
                r_hin <= afv_pkg::key_byte(i_cfg.key, 4'(r_k));
                r_k   <= r_k + 1'b1;
            end
            afv_pkg::ST_MUL1: r_m1 <= (r_h ^ {24'h0, r_hin}) * afv_pkg::HASH_MUL1;
            afv_pkg::ST_MUL2: begin
                r_h <= (r_m1 ^ (r_m1 >> 15)) * afv_pkg::HASH_MUL2;
                if (r_phase == afv_pkg::PH_BYTE) r_k <= '0;
            end
            afv_pkg::ST_BYTE: begin
                if (w_do_crc) r_crc <= afv_pkg::crc_byte(r_crc, r_b);
                r_hin <= w_hin;
                r_k   <= '0;
                if (r_pos == PW'(0)) begin
                    r_len <= r_b;
                end else if (r_pos == PW'(1)) begin
                    if (r_b != i_cfg.magic && r_eerr == afv_pkg::STS_OK)
                        r_eerr <= afv_pkg::STS_HEADER;
                end else if (r_pos == PW'(2)) begin
                    if (r_b != i_cfg.version && r_eerr == afv_pkg::STS_OK)
                        r_eerr <= afv_pkg::STS_HEADER;
                end else if (r_pos <= PW'(6)) begin
                    r_ctr[{r_pos[1:0] - 2'd3, 3'b000} +: 8] <= r_b;
                end else if (r_pos == PW'(7)) begin
                    r_cmd <= r_b;
                end else if (r_pos == PW'(8)) begin
                    r_argc <= r_b;
                    if (r_b > 8'(afv_pkg::ARGS_MAX) && r_eerr == afv_pkg::STS_OK)
                        r_eerr <= afv_pkg::STS_ARGS;
                end else if (!w_in_args) begin
                    if (w_rel_x < w_argc_x + 10'd4) begin
                        r_mac[{w_rel[1:0] - r_argc[1:0], 3'b000} +: 8] <= r_b;
                    end else if (w_rel_x == w_argc_x + 10'd4) begin
                        r_rcrc[7:0] <= r_b;
                    end else if (w_rel_x == w_argc_x + 10'd5) begin
                        r_rcrc[15:8] <= r_b;
                    end
                end
            end
            afv_pkg::ST_CHECK:  r_st <= w_st;
            afv_pkg::ST_STATUS: r_ai <= '0;
            afv_pkg::ST_ARGOUT: if (w_load_arg) r_ai <= r_ai + 1'b1;
            default: ;
        endcase
    end

    // Argument store: written while bytes are taken, read one entry per argument result on the way out.
    always_ff @(posedge i_clk) begin
        if (r_state == afv_pkg::ST_BYTE && w_in_args &&
            w_rel < PW'(afv_pkg::ARGS_MAX)) begin
            r_mem[w_rel[afv_pkg::AW-1:0]] <= r_b;
        end
        r_rdata <= r_mem[r_ai[afv_pkg::AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load_status || w_load_arg) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_status) begin
            r_okind   <= 1'b0;
            r_ostatus <= r_st;
            r_obyte   <= '0;
            r_oidx    <= '0;
            if (r_st == afv_pkg::STS_OK) begin
                r_octr <= r_ctr;
                r_ocmd <= r_cmd;
                r_ocnt <= 6'(r_argc);
                r_oend <= (r_argc == 8'd0);
            end else begin
                r_octr <= '0;
                r_ocmd <= '0;
                r_ocnt <= '0;
                r_oend <= 1'b1;
            end
        end else if (w_load_arg) begin
            r_okind <= 1'b1;
            r_obyte <= r_rdata;
            r_oidx  <= 5'(r_ai);
            r_oend  <= w_arg_last;
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_kind        = r_okind;
    assign o_status      = r_ostatus;
    assign o_msg_counter = r_octr;
    assign o_command     = r_ocmd;
    assign o_arg_count   = r_ocnt;
    assign o_arg_byte    = r_obyte;
    assign o_arg_index   = r_oidx;
    assign o_run_end     = r_oend;

`ifndef SYNTH
    a_mul_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == afv_pkg::ST_MUL1 |=> r_state == afv_pkg::ST_MUL2)
        else $error("hash round broken");
    a_arg_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_okind |-> r_ostatus == afv_pkg::STS_OK)
        else $error("argument result on a failed frame");
`endif

endmodule
`default_nettype wire
